@@ rtl/wpr_pkg.sv @@
// Shared types and constants for the weighted phase remap block.
package wpr_pkg;

    localparam int LEAVES_DEF = 256;
    localparam int LEAF_IDX_W = 12;
    localparam int PHASE_W    = 16;
    localparam int WEIGHT_W   = 16;
    localparam int FUNC_W     = 2;
    localparam int HIT_W      = 8;

    localparam int DIV_QUO_W = 17;
    localparam int DIV_DEN_W = 16;
    localparam int DIV_NUM_W = DIV_QUO_W + DIV_DEN_W;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_SET_INDEX = 2'd0,
        FUNC_SET_PHASE = 2'd1,
        FUNC_REMAP     = 2'd2,
        FUNC_NONE      = 2'd3
    } t_func;

    typedef enum logic {
        OP_SET   = 1'b0,
        OP_REMAP = 1'b1
    } t_op;

    typedef struct packed {
        t_op                   op;
        logic [LEAF_IDX_W-1:0] leaf;
        logic [PHASE_W-1:0]    phase;
        logic [WEIGHT_W-1:0]   weight;
    } t_cmd;

endpackage

@@ rtl/wpr_front.sv @@
// Front end: accepts input beats and turns them into tree commands.
module wpr_front #(
    parameter int LEAVES = wpr_pkg::LEAVES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [wpr_pkg::FUNC_W-1:0]   i_func,
    input  logic [7:0]                   i_leaf_index,
    input  logic [wpr_pkg::PHASE_W-1:0]  i_phase_in,
    input  logic [wpr_pkg::WEIGHT_W-1:0] i_weight,
    output logic                         o_cmd_valid,
    input  logic                         i_cmd_ready,
    output wpr_pkg::t_cmd                o_cmd
);
    import wpr_pkg::*;

    localparam int CMP_W  = LEAF_IDX_W + 1;
    localparam int PROD_W = PHASE_W + CMP_W;

    logic             r_valid;
    logic             n_valid;
    t_cmd             r_cmd;
    t_cmd             n_cmd;
    logic             keep;
    logic             accept;
    logic [PROD_W-1:0] phase_prod;

    assign o_in_ready  = !r_valid || i_cmd_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    // Leaf owning a phase: floor(phase * LEAVES / 2^16).
    assign phase_prod = PROD_W'(i_phase_in) * PROD_W'(LEAVES);

    always_comb begin
        n_cmd.weight = i_weight;
        n_cmd.phase  = i_phase_in;
        n_cmd.op     = OP_SET;
        n_cmd.leaf   = LEAF_IDX_W'(i_leaf_index);
        keep         = 1'b0;
        unique case (t_func'(i_func))
            FUNC_SET_INDEX: begin
                keep = CMP_W'(i_leaf_index) < CMP_W'(LEAVES);
            end
            FUNC_SET_PHASE: begin
                n_cmd.leaf = phase_prod[PHASE_W +: LEAF_IDX_W];
                keep       = 1'b1;
            end
            FUNC_REMAP: begin
                n_cmd.op = OP_REMAP;
                keep     = 1'b1;
            end
            FUNC_NONE: begin
                keep = 1'b0;
            end
        endcase
        n_valid = r_valid && !i_cmd_ready;
        if (accept) begin
            n_valid = keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

@@ rtl/wpr_queue.sv @@
// Two-entry command queue between the front end and the tree engine.
module wpr_queue #(
    parameter int W = $bits(wpr_pkg::t_cmd)
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push_valid,
    output logic         o_push_ready,
    input  logic [W-1:0] i_push_data,
    output logic         o_pop_valid,
    input  logic         i_pop_ready,
    output logic [W-1:0] o_pop_data
);
    import wpr_pkg::*;

    logic [W-1:0] r_mem [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;
    logic         push;
    logic         pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_pop_valid  = (r_cnt != 2'd0);
    assign o_pop_data   = r_mem[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
        if (push) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

endmodule

@@ rtl/wpr_div.sv @@
// Restoring serial divider, one quotient bit per cycle.
module wpr_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [wpr_pkg::DIV_NUM_W-1:0] i_num,
    input  logic [wpr_pkg::DIV_DEN_W-1:0] i_den,
    output logic                          o_done,
    output logic [wpr_pkg::DIV_QUO_W-1:0] o_quo
);
    import wpr_pkg::*;

    localparam int CNT_W = $clog2(DIV_QUO_W + 1);

    // The caller guarantees that the numerator's upper part is below the divisor,
    // so the quotient fits in DIV_QUO_W bits.
    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_QUO_W-1:0] r_quo;
    logic [DIV_DEN_W:0]   shifted;
    logic [DIV_DEN_W:0]   diff;
    logic                 ge;

    assign shifted = {r_rem, r_quo[DIV_QUO_W-1]};
    assign diff    = shifted - {1'b0, r_den};
    assign ge      = shifted >= {1'b0, r_den};
    assign o_done  = r_done;
    assign o_quo   = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_QUO_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
        if (i_start) begin
            r_rem <= i_num[DIV_NUM_W-1:DIV_QUO_W];
            r_quo <= i_num[DIV_QUO_W-1:0];
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
            r_quo <= {r_quo[DIV_QUO_W-2:0], ge};
        end
    end

endmodule

@@ rtl/wpr_tree.sv @@
// Tree engine: sum tree memories, weight updates, descent and remap arithmetic.
module wpr_tree #(
    parameter int LEAVES = wpr_pkg::LEAVES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cmd_valid,
    output logic                        o_cmd_ready,
    input  wpr_pkg::t_cmd               i_cmd,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [wpr_pkg::PHASE_W-1:0] o_phase_out,
    output logic [wpr_pkg::HIT_W-1:0]   o_hit_leaf
);
    import wpr_pkg::*;

    localparam int LG      = $clog2(LEAVES);
    localparam int P       = 1 << LG;
    localparam int SUM_W   = WEIGHT_W + LG;
    localparam int NODE_W  = LG + 1;
    localparam int WANT_W  = PHASE_W + SUM_W;
    localparam int NUM2_W  = LG + DIV_QUO_W;
    localparam bit IS_POW2 = (P == LEAVES);

    // Division by LEAVES as a multiply by a rounded-up reciprocal; exact for every
    // numerator below 2^NUM2_W.
    localparam int RSH     = NUM2_W + LG;
    localparam int RECIP_W = NUM2_W + 1;
    localparam int MPROD_W = NUM2_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RSH) + 64'(LEAVES) - 64'd1) / 64'(LEAVES));

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_SET, S_ROOT, S_DESC, S_LEAF, S_DIV_W, S_POS, S_MUL_P, S_OUT
    } t_state;

    // Heap layout: node 1 is the root, node n has children 2n and 2n+1, and leaf i
    // is node P+i. Leaves past LEAVES hold zero and are never reached by a descent.
    logic [WEIGHT_W-1:0] leaf_mem [P];
    logic [SUM_W-1:0]    sum_mem  [P];

    t_state               r_state;
    logic [LG-1:0]        r_clr;
    logic [NODE_W-1:0]    r_node;
    logic [SUM_W-1:0]     r_val;
    logic [WANT_W-1:0]    r_want;
    logic [PHASE_W-1:0]   r_phase;
    logic [LG-1:0]        r_leaf;
    logic [DIV_QUO_W-1:0] r_frac;
    logic [NUM2_W-1:0]    r_num2;
    logic [PHASE_W-1:0]   r_pos;
    logic                 r_out_valid;
    logic [PHASE_W-1:0]   r_phase_out;
    logic [HIT_W-1:0]     r_hit_leaf;
    logic [WEIGHT_W-1:0]  leaf_rd;
    logic [SUM_W-1:0]     sum_rd;

    logic                 leaf_we;
    logic [LG-1:0]        leaf_wa;
    logic [WEIGHT_W-1:0]  leaf_wd;
    logic [LG-1:0]        leaf_ra;
    logic                 sum_we;
    logic [LG-1:0]        sum_wa;
    logic [SUM_W-1:0]     sum_wd;
    logic [LG-1:0]        sum_ra;

    logic [NODE_W-1:0]    lc_prev;
    logic [SUM_W-1:0]     left;
    logic [WANT_W-1:0]    left_sh;
    logic                 go_left;
    logic [NODE_W-1:0]    nn;
    logic [NODE_W-1:0]    rd_node;
    logic [NODE_W-1:0]    lc_next;
    logic [SUM_W-1:0]     sib;
    logic [SUM_W-1:0]     sum_new;
    logic [LG-1:0]        parent;
    logic [LG-1:0]        cmd_leaf;
    logic [NUM2_W-1:0]    num2;
    logic [MPROD_W-1:0]   pos_prod;
    logic [LEAF_IDX_W-1:0] leaf_ext;
    logic [WANT_W-1:0]    want_prod;
    logic                 div_start;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic                 div_done;
    logic [DIV_QUO_W-1:0] div_quo;
    logic                 out_load;

    // Number of real leaves below internal node k, used by the clearing sweep.
    function automatic logic [SUM_W-1:0] count_below(input logic [LG-1:0] k);
        int lvl;
        int span;
        int first;
        int cnt;
        lvl = 0;
        cnt = 0;
        for (int b = 0; b < LG; b++) begin
            if (k[b]) begin
                lvl = b;
            end
        end
        span  = P >> lvl;
        first = (int'(k) << (LG - lvl)) - P;
        if (k == '0 || first >= LEAVES) begin
            cnt = 0;
        end else if (LEAVES - first > span) begin
            cnt = span;
        end else begin
            cnt = LEAVES - first;
        end
        return SUM_W'(cnt);
    endfunction

    wpr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign o_cmd_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_phase_out = r_phase_out;
    assign o_hit_leaf  = r_hit_leaf;
    assign cmd_leaf    = i_cmd.leaf[LG-1:0];
    assign leaf_ext    = LEAF_IDX_W'(r_leaf);
    assign out_load    = (r_state == S_OUT) && (!r_out_valid || i_out_ready);
    assign want_prod   = WANT_W'(r_phase) * WANT_W'(sum_rd);
    assign pos_prod    = MPROD_W'(r_num2) * MPROD_W'(RECIP);

    always_comb begin
        // Descent step: compare the left child's weight against the target.
        lc_prev = {r_node[LG-1:0], 1'b0};
        left    = lc_prev[LG] ? SUM_W'(leaf_rd) : sum_rd;
        left_sh = {left, {PHASE_W{1'b0}}};
        go_left = left_sh >= r_want;
        nn      = go_left ? lc_prev : (lc_prev | NODE_W'(1));
        rd_node = (r_state == S_ROOT) ? NODE_W'(1) : nn;
        lc_next = {rd_node[LG-1:0], 1'b0};

        // Update step: new parent sum from the running value and the sibling.
        sib     = r_node[LG] ? SUM_W'(leaf_rd) : sum_rd;
        sum_new = r_val + sib;
        parent  = r_node[LG:1];

        num2 = {r_leaf, {PHASE_W{1'b0}}} + NUM2_W'(r_frac);

        leaf_we   = 1'b0;
        leaf_wa   = r_clr;
        leaf_wd   = '0;
        leaf_ra   = '0;
        sum_we    = 1'b0;
        sum_wa    = r_clr;
        sum_wd    = '0;
        sum_ra    = '0;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;

        unique case (r_state)
            S_CLEAR: begin
                leaf_we = 1'b1;
                leaf_wd = ({1'b0, r_clr} < NODE_W'(LEAVES)) ? WEIGHT_W'(1) : '0;
                sum_we  = 1'b1;
                sum_wd  = count_below(r_clr);
            end
            S_IDLE: begin
                if (i_cmd_valid && i_cmd.op == OP_SET) begin
                    leaf_we = 1'b1;
                    leaf_wa = cmd_leaf;
                    leaf_wd = i_cmd.weight;
                    leaf_ra = cmd_leaf ^ LG'(1);
                end else begin
                    sum_ra = LG'(1);
                end
            end
            S_SET: begin
                sum_we = 1'b1;
                sum_wa = parent;
                sum_wd = sum_new;
                sum_ra = parent ^ LG'(1);
            end
            S_ROOT, S_DESC: begin
                leaf_ra = rd_node[LG] ? rd_node[LG-1:0] : lc_next[LG-1:0];
                sum_ra  = lc_next[LG-1:0];
            end
            S_LEAF: begin
                div_start = (leaf_rd != '0);
                div_num   = r_want[DIV_NUM_W-1:0];
                div_den   = leaf_rd;
            end
            S_DIV_W, S_POS, S_MUL_P, S_OUT: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (leaf_we) begin
            leaf_mem[leaf_wa] <= leaf_wd;
        end
        leaf_rd <= leaf_mem[leaf_ra];
    end

    always_ff @(posedge i_clk) begin
        if (sum_we) begin
            sum_mem[sum_wa] <= sum_wd;
        end
        sum_rd <= sum_mem[sum_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + LG'(1);
                    if (r_clr == LG'(P - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        if (i_cmd.op == OP_SET) begin
                            r_node  <= {1'b1, cmd_leaf};
                            r_val   <= SUM_W'(i_cmd.weight);
                            r_state <= S_SET;
                        end else begin
                            r_phase <= i_cmd.phase;
                            r_state <= S_ROOT;
                        end
                    end
                end
                S_SET: begin
                    r_node <= {1'b0, parent};
                    r_val  <= sum_new;
                    if (parent == LG'(1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_ROOT: begin
                    r_want  <= want_prod;
                    r_node  <= NODE_W'(1);
                    r_state <= S_DESC;
                end
                S_DESC: begin
                    r_node <= nn;
                    if (!go_left) begin
                        r_want <= r_want - left_sh;
                    end
                    if (nn[LG]) begin
                        r_state <= S_LEAF;
                    end
                end
                S_LEAF: begin
                    r_leaf <= r_node[LG-1:0];
                    if (leaf_rd == '0) begin
                        r_frac  <= '0;
                        r_state <= S_POS;
                    end else begin
                        r_state <= S_DIV_W;
                    end
                end
                S_DIV_W: begin
                    if (div_done) begin
                        r_frac  <= div_quo;
                        r_state <= S_POS;
                    end
                end
                S_POS: begin
                    if (IS_POW2) begin
                        r_pos   <= PHASE_W'(num2 >> LG);
                        r_state <= S_OUT;
                    end else begin
                        r_num2  <= num2;
                        r_state <= S_MUL_P;
                    end
                end
                S_MUL_P: begin
                    r_pos   <= pos_prod[RSH +: PHASE_W];
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
        if (out_load) begin
            r_phase_out <= r_pos;
            r_hit_leaf  <= leaf_ext[HIT_W-1:0];
        end
    end

endmodule

@@ rtl/weighted_phase_remap.sv @@
// Top level of the weighted phase remap block: front end, command queue, tree engine.
//
// The input channel (i_in_valid / o_in_ready) carries one beat per operation:
// i_func selects set-weight-by-index, set-weight-by-phase or remap. Set beats,
// beats with an out-of-range index and the unused selector produce no output.
// Each remap beat produces exactly one output beat (o_out_valid / i_out_ready)
// with the remapped phase and the leaf the descent reached, in input order.
// A front register classifies beats and a two-entry queue feeds the tree
// engine, so the input keeps flowing while the engine works or waits, until the
// queue and the front register are full. The engine handles one command at a time.
// A set does one sum-memory write per tree level. A remap does the root read and
// multiply, one read per level of descent, the leaf read, a wait on the serial
// divide by the leaf weight (skipped for a zero weight), scaling by 1/LEAVES (with
// an extra multiply step when LEAVES is not a power of two) and the output load.
// After reset the engine runs a clearing pass over all 2^ceil(log2(LEAVES)) leaf
// slots that loads every real leaf weight with one, every padding leaf with zero and
// every subtree sum with its leaf count; input beats are held off once the queue
// and the front register fill during that pass.
// When the receiver stalls, the result waits in the output register and the
// engine holds the next result until that register frees up.
module weighted_phase_remap #(
    parameter int LEAVES = wpr_pkg::LEAVES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [wpr_pkg::FUNC_W-1:0]   i_func,
    input  logic [7:0]                   i_leaf_index,
    input  logic [wpr_pkg::PHASE_W-1:0]  i_phase_in,
    input  logic [wpr_pkg::WEIGHT_W-1:0] i_weight,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [wpr_pkg::PHASE_W-1:0]  o_phase_out,
    output logic [wpr_pkg::HIT_W-1:0]    o_hit_leaf
);
    import wpr_pkg::*;

    localparam int CMD_W = $bits(t_cmd);

    logic             front_valid;
    logic             front_ready;
    t_cmd             front_cmd;
    logic             queue_valid;
    logic             queue_ready;
    logic [CMD_W-1:0] queue_data;

    // Classifies beats and drops the ones that do nothing.
    wpr_front #(
        .LEAVES (LEAVES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_func       (i_func),
        .i_leaf_index (i_leaf_index),
        .i_phase_in   (i_phase_in),
        .i_weight     (i_weight),
        .o_cmd_valid  (front_valid),
        .i_cmd_ready  (front_ready),
        .o_cmd        (front_cmd)
    );

    // Decouples the front end from the multi-cycle engine.
    wpr_queue #(
        .W (CMD_W)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_data  (front_cmd),
        .o_pop_valid  (queue_valid),
        .i_pop_ready  (queue_ready),
        .o_pop_data   (queue_data)
    );

    // Owns the weight and sum memories and produces remap results.
    wpr_tree #(
        .LEAVES (LEAVES)
    ) u_tree (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (queue_valid),
        .o_cmd_ready (queue_ready),
        .i_cmd       (t_cmd'(queue_data)),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_phase_out (o_phase_out),
        .o_hit_leaf  (o_hit_leaf)
    );

endmodule
